@@ rtl/mbq_pkg.sv @@
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types, constants and microprogram table for the multichannel biquad.
// ----------------------------------------------------------------------------
package mbq_pkg;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int STATE_W  = 40;
    localparam int ACC_W    = 48;
    localparam int MUL_A_W  = 24;
    localparam int PROD_W   = MUL_A_W + COEF_W;
    localparam int LO_W     = PROD_W - 16;
    localparam int PC_W     = 4;
    localparam int ROW_W    = 4 * STATE_W;
    localparam int REG_IDX_W = 3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_COEF_B0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_B2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A1   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A2   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STRUCTURE = 3'd5;

    typedef enum logic [1:0] {
        STRUCT_DF1  = 2'd0,
        STRUCT_DF2  = 2'd1,
        STRUCT_TDF1 = 2'd2,
        STRUCT_TDF2 = 2'd3
    } structure_t;

    typedef enum logic [2:0] {
        K_LOAD,
        K_ADD,
        K_MAC,
        K_STORE,
        K_DONE
    } kind_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_X,
        SRC_Y,
        SRC_W,
        SRC_D0,
        SRC_D1,
        SRC_D2,
        SRC_D3
    } src_t;

    typedef enum logic [2:0] {
        CF_B0,
        CF_B1,
        CF_B2,
        CF_A1,
        CF_A2
    } coef_t;

    typedef enum logic [2:0] {
        DST_W,
        DST_Y,
        DST_N0,
        DST_N1,
        DST_N2,
        DST_N3
    } dst_t;

    typedef struct packed {
        kind_t kind;
        src_t  src;
        coef_t coef;
        dst_t  dst;
    } instr_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_FETCH,
        DP_LOAD,
        DP_ADD,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_ACC,
        DP_STORE,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        src_t   src;
        coef_t  coef;
        dst_t   dst;
    } dp_cmd_t;

    typedef struct packed {
        logic       in_range;
        logic       out_free;
        structure_t structure;
    } dp_status_t;

    function automatic instr_t mk(kind_t k, src_t s, coef_t c, dst_t d);
        instr_t r;
        r.kind = k;
        r.src  = s;
        r.coef = c;
        r.dst  = d;
        return r;
    endfunction

    // delay slots d0..d3 per structure:
    //   direct I:      x1, x2, y1, y2
    //   direct II:     w1, w2
    //   transposed I:  in1, in2, mid1, mid2
    //   transposed II: in1, in2
    // store loads the accumulator with src in the same cycle
    function automatic instr_t prog(structure_t s, logic [PC_W-1:0] pc);
        instr_t r;
        r = mk(K_DONE, SRC_ZERO, CF_B0, DST_Y);
        case (s)
            STRUCT_DF1: begin
                case (pc)
                    4'd0: r = mk(K_LOAD,  SRC_ZERO, CF_B0, DST_Y);
                    4'd1: r = mk(K_MAC,   SRC_X,    CF_B0, DST_Y);
                    4'd2: r = mk(K_MAC,   SRC_D0,   CF_B1, DST_Y);
                    4'd3: r = mk(K_MAC,   SRC_D1,   CF_B2, DST_Y);
                    4'd4: r = mk(K_MAC,   SRC_D2,   CF_A1, DST_Y);
                    4'd5: r = mk(K_MAC,   SRC_D3,   CF_A2, DST_Y);
                    4'd6: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_Y);
                    default: r = mk(K_DONE, SRC_ZERO, CF_B0, DST_Y);
                endcase
            end
            STRUCT_DF2: begin
                case (pc)
                    4'd0: r = mk(K_LOAD,  SRC_X,    CF_B0, DST_Y);
                    4'd1: r = mk(K_MAC,   SRC_D0,   CF_A1, DST_Y);
                    4'd2: r = mk(K_MAC,   SRC_D1,   CF_A2, DST_Y);
                    4'd3: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_W);
                    4'd4: r = mk(K_MAC,   SRC_W,    CF_B0, DST_Y);
                    4'd5: r = mk(K_MAC,   SRC_D0,   CF_B1, DST_Y);
                    4'd6: r = mk(K_MAC,   SRC_D1,   CF_B2, DST_Y);
                    4'd7: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_Y);
                    default: r = mk(K_DONE, SRC_ZERO, CF_B0, DST_Y);
                endcase
            end
            STRUCT_TDF1: begin
                case (pc)
                    4'd0:  r = mk(K_LOAD,  SRC_X,    CF_B0, DST_Y);
                    4'd1:  r = mk(K_ADD,   SRC_D3,   CF_B0, DST_Y);
                    4'd2:  r = mk(K_STORE, SRC_D1,   CF_B0, DST_W);
                    4'd3:  r = mk(K_MAC,   SRC_W,    CF_B0, DST_Y);
                    4'd4:  r = mk(K_STORE, SRC_D0,   CF_B0, DST_Y);
                    4'd5:  r = mk(K_MAC,   SRC_W,    CF_B1, DST_Y);
                    4'd6:  r = mk(K_STORE, SRC_D2,   CF_B0, DST_N1);
                    4'd7:  r = mk(K_MAC,   SRC_W,    CF_A1, DST_Y);
                    4'd8:  r = mk(K_STORE, SRC_ZERO, CF_B0, DST_N3);
                    4'd9:  r = mk(K_MAC,   SRC_W,    CF_B2, DST_Y);
                    4'd10: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_N0);
                    4'd11: r = mk(K_MAC,   SRC_W,    CF_A2, DST_Y);
                    4'd12: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_N2);
                    default: r = mk(K_DONE, SRC_ZERO, CF_B0, DST_Y);
                endcase
            end
            default: begin
                case (pc)
                    4'd0: r = mk(K_LOAD,  SRC_D1,   CF_B0, DST_Y);
                    4'd1: r = mk(K_MAC,   SRC_X,    CF_B0, DST_Y);
                    4'd2: r = mk(K_STORE, SRC_D0,   CF_B0, DST_Y);
                    4'd3: r = mk(K_MAC,   SRC_X,    CF_B1, DST_Y);
                    4'd4: r = mk(K_MAC,   SRC_Y,    CF_A1, DST_Y);
                    4'd5: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_N1);
                    4'd6: r = mk(K_MAC,   SRC_X,    CF_B2, DST_Y);
                    4'd7: r = mk(K_MAC,   SRC_Y,    CF_A2, DST_Y);
                    4'd8: r = mk(K_STORE, SRC_ZERO, CF_B0, DST_N0);
                    default: r = mk(K_DONE, SRC_ZERO, CF_B0, DST_Y);
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/mbq_ram.sv @@
// ----------------------------------------------------------------------------
// mbq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbq_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/mbq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbq_ctrl
// Sequencer: walks the microprogram of the selected structure and issues
// datapath commands; each product term issues MUL_LO, MUL_HI and ACC in turn.
// ----------------------------------------------------------------------------
module mbq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mbq_pkg::dp_status_t status,
    output mbq_pkg::dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_MUL_HI = 6'b001000,
        ST_ACC    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [mbq_pkg::PC_W-1:0]   pc_reg, pc_next;
    mbq_pkg::instr_t            instr;

    assign instr    = mbq_pkg::prog(status.structure, pc_reg);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cmd.op     = mbq_pkg::DP_NOP;
        cmd.src    = instr.src;
        cmd.coef   = instr.coef;
        cmd.dst    = instr.dst;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = mbq_pkg::DP_ACCEPT;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.op     = mbq_pkg::DP_FETCH;
                pc_next    = '0;
                state_next = status.in_range ? ST_EXEC : ST_FINISH;
            end
            ST_EXEC: begin
                case (instr.kind)
                    mbq_pkg::K_LOAD: begin
                        cmd.op  = mbq_pkg::DP_LOAD;
                        pc_next = pc_reg + 1'b1;
                    end
                    mbq_pkg::K_ADD: begin
                        cmd.op  = mbq_pkg::DP_ADD;
                        pc_next = pc_reg + 1'b1;
                    end
                    mbq_pkg::K_STORE: begin
                        cmd.op  = mbq_pkg::DP_STORE;
                        pc_next = pc_reg + 1'b1;
                    end
                    mbq_pkg::K_MAC: begin
                        cmd.op     = mbq_pkg::DP_MUL_LO;
                        state_next = ST_MUL_HI;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_MUL_HI: begin
                cmd.op     = mbq_pkg::DP_MUL_HI;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = mbq_pkg::DP_ACC;
                pc_next    = pc_reg + 1'b1;
                state_next = ST_EXEC;
            end
            ST_FINISH: begin
                // wait for the output register to drain
                if (status.out_free) begin
                    cmd.op     = mbq_pkg::DP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

@@ rtl/mbq_datapath.sv @@
// ----------------------------------------------------------------------------
// mbq_datapath
// Coefficient registers, per-channel delay memory, shared 24x32 multiplier,
// 48-bit accumulator with saturation, and the output register.
// ----------------------------------------------------------------------------
module mbq_datapath #(
    parameter int CHANNELS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mbq_pkg::dp_cmd_t                   cmd,
    output mbq_pkg::dp_status_t                status,
    input  logic [31:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [mbq_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [mbq_pkg::COEF_W-1:0]         cfg_wr_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = mbq_pkg::STATE_W;

    // configuration
    logic signed [mbq_pkg::COEF_W-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [mbq_pkg::COEF_W-1:0] coef_a1_reg, coef_a2_reg;
    mbq_pkg::structure_t               structure_reg;
    logic [CHANNELS-1:0]               valid_reg;

    // working registers
    logic [mbq_pkg::CHAN_W-1:0]          chan_reg;
    logic signed [mbq_pkg::SAMPLE_W-1:0] x_reg, y_reg;
    logic signed [SW-1:0]                w_reg;
    logic signed [SW-1:0]                d_reg [4];
    logic signed [SW-1:0]                n_reg [4];
    logic signed [mbq_pkg::ACC_W-1:0]    acc_reg;
    logic signed [mbq_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mbq_pkg::LO_W-1:0]     lo_reg;

    // output register
    logic                                m_valid_reg;
    logic [mbq_pkg::CHAN_W-1:0]          out_chan_reg;
    logic [mbq_pkg::SAMPLE_W-1:0]        out_sample_reg;

    logic [AW+mbq_pkg::CHAN_W-1:0] s_chan_ext, chan_ext;
    logic [AW-1:0]                 s_addr, chan_addr;
    logic                          in_range;
    logic [mbq_pkg::ROW_W-1:0]     ram_rdata, ram_wdata;
    logic                          ram_we;

    logic signed [SW-1:0]                src_val;
    logic signed [mbq_pkg::COEF_W-1:0]   coef_val;
    logic signed [mbq_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [mbq_pkg::PROD_W-1:0]   mul_p;
    logic signed [mbq_pkg::PROD_W:0]     term_sum;
    logic signed [mbq_pkg::ACC_W-1:0]    term;
    logic signed [SW-1:0]                acc_sat_state;
    logic signed [mbq_pkg::SAMPLE_W-1:0] acc_sat_sample;
    logic signed [SW-1:0]                x_ext, y_ext;

    function automatic logic signed [SW-1:0] sat_state(
        logic signed [mbq_pkg::ACC_W-1:0] v
    );
        logic [mbq_pkg::ACC_W-SW:0] top;
        top = v[mbq_pkg::ACC_W-1:SW-1];
        if ((&top) || !(|top)) begin
            return v[SW-1:0];
        end
        return v[mbq_pkg::ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    endfunction

    function automatic logic signed [mbq_pkg::SAMPLE_W-1:0] sat_sample(
        logic signed [mbq_pkg::ACC_W-1:0] v
    );
        logic [mbq_pkg::ACC_W-mbq_pkg::SAMPLE_W:0] top;
        top = v[mbq_pkg::ACC_W-1:mbq_pkg::SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return v[mbq_pkg::SAMPLE_W-1:0];
        end
        return v[mbq_pkg::ACC_W-1] ? {1'b1, {(mbq_pkg::SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(mbq_pkg::SAMPLE_W-1){1'b1}}};
    endfunction

    assign s_chan_ext = {{AW{1'b0}}, s_tdata[mbq_pkg::CHAN_W-1:0]};
    assign s_addr     = s_chan_ext[AW-1:0];
    assign chan_ext   = {{AW{1'b0}}, chan_reg};
    assign chan_addr  = chan_ext[AW-1:0];
    assign in_range   = (chan_ext < CHANNELS);

    assign status.in_range  = in_range;
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.structure = structure_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(32 - mbq_pkg::SAMPLE_W - mbq_pkg::CHAN_W){1'b0}},
                       out_sample_reg, out_chan_reg};

    assign x_ext = {{(SW - mbq_pkg::SAMPLE_W){x_reg[mbq_pkg::SAMPLE_W-1]}}, x_reg};
    assign y_ext = {{(SW - mbq_pkg::SAMPLE_W){y_reg[mbq_pkg::SAMPLE_W-1]}}, y_reg};

    always_comb begin
        case (cmd.src)
            mbq_pkg::SRC_X:  src_val = x_ext;
            mbq_pkg::SRC_Y:  src_val = y_ext;
            mbq_pkg::SRC_W:  src_val = w_reg;
            mbq_pkg::SRC_D0: src_val = d_reg[0];
            mbq_pkg::SRC_D1: src_val = d_reg[1];
            mbq_pkg::SRC_D2: src_val = d_reg[2];
            mbq_pkg::SRC_D3: src_val = d_reg[3];
            default:         src_val = '0;
        endcase
    end

    always_comb begin
        case (cmd.coef)
            mbq_pkg::CF_B0: coef_val = coef_b0_reg;
            mbq_pkg::CF_B1: coef_val = coef_b1_reg;
            mbq_pkg::CF_B2: coef_val = coef_b2_reg;
            mbq_pkg::CF_A1: coef_val = coef_a1_reg;
            mbq_pkg::CF_A2: coef_val = coef_a2_reg;
            default:        coef_val = '0;
        endcase
    end

    // operand split: low 16 bits unsigned, upper 24 bits signed
    assign mul_a = (cmd.op == mbq_pkg::DP_MUL_LO)
                 ? {{(mbq_pkg::MUL_A_W - 16){1'b0}}, src_val[15:0]}
                 : src_val[SW-1:16];
    assign mul_p = mul_a * coef_val;

    // floor(hi * c / 2^12 + floor(lo * c / 2^16) / 2^12) == floor(s * c / 2^28)
    assign term_sum = {prod_reg[mbq_pkg::PROD_W-1], prod_reg}
                    + {{(mbq_pkg::PROD_W + 1 - mbq_pkg::LO_W){lo_reg[mbq_pkg::LO_W-1]}},
                       lo_reg};
    assign term = {{(mbq_pkg::ACC_W - (mbq_pkg::PROD_W + 1 - 12)){term_sum[mbq_pkg::PROD_W]}},
                   term_sum[mbq_pkg::PROD_W:12]};

    assign acc_sat_state  = sat_state(acc_reg);
    assign acc_sat_sample = sat_sample(acc_reg);

    always_comb begin
        case (structure_reg)
            mbq_pkg::STRUCT_DF1:
                ram_wdata = {d_reg[2], y_ext, d_reg[0], x_ext};
            mbq_pkg::STRUCT_DF2:
                ram_wdata = {d_reg[3], d_reg[2], d_reg[0], w_reg};
            default:
                ram_wdata = {n_reg[3], n_reg[2], n_reg[1], n_reg[0]};
        endcase
    end

    assign ram_we = (cmd.op == mbq_pkg::DP_FINISH) && in_range;

    mbq_ram #(
        .WIDTH (mbq_pkg::ROW_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (chan_addr),
        .wr_data (ram_wdata),
        .rd_addr (s_addr),
        .rd_data (ram_rdata)
    );

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg   <= 32'sd268435456;
            coef_b1_reg   <= '0;
            coef_b2_reg   <= '0;
            coef_a1_reg   <= '0;
            coef_a2_reg   <= '0;
            structure_reg <= mbq_pkg::STRUCT_TDF2;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mbq_pkg::REG_COEF_B0: coef_b0_reg <= cfg_wr_data;
                    mbq_pkg::REG_COEF_B1: coef_b1_reg <= cfg_wr_data;
                    mbq_pkg::REG_COEF_B2: coef_b2_reg <= cfg_wr_data;
                    mbq_pkg::REG_COEF_A1: coef_a1_reg <= cfg_wr_data;
                    mbq_pkg::REG_COEF_A2: coef_a2_reg <= cfg_wr_data;
                    mbq_pkg::REG_STRUCTURE: begin
                        // a new structure starts every channel from zero
                        if (cfg_wr_data[1:0] != structure_reg) begin
                            structure_reg <= mbq_pkg::structure_t'(cfg_wr_data[1:0]);
                            valid_reg     <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (ram_we) begin
                valid_reg[chan_addr] <= 1'b1;
            end
            if (cmd.op == mbq_pkg::DP_FINISH) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            mbq_pkg::DP_ACCEPT: begin
                chan_reg <= s_tdata[mbq_pkg::CHAN_W-1:0];
                x_reg    <= s_tdata[mbq_pkg::CHAN_W +: mbq_pkg::SAMPLE_W];
            end
            mbq_pkg::DP_FETCH: begin
                // rows of channels not yet written read as zero
                for (int i = 0; i < 4; i++) begin
                    d_reg[i] <= valid_reg[chan_addr] ? ram_rdata[i*SW +: SW] : '0;
                end
                y_reg <= '0;
            end
            mbq_pkg::DP_LOAD: begin
                acc_reg <= {{(mbq_pkg::ACC_W - SW){src_val[SW-1]}}, src_val};
            end
            mbq_pkg::DP_ADD: begin
                acc_reg <= acc_reg + {{(mbq_pkg::ACC_W - SW){src_val[SW-1]}}, src_val};
            end
            mbq_pkg::DP_MUL_LO: begin
                prod_reg <= mul_p;
            end
            mbq_pkg::DP_MUL_HI: begin
                prod_reg <= mul_p;
                lo_reg   <= prod_reg[mbq_pkg::PROD_W-1:16];
            end
            mbq_pkg::DP_ACC: begin
                acc_reg <= acc_reg + term;
            end
            mbq_pkg::DP_STORE: begin
                case (cmd.dst)
                    mbq_pkg::DST_W:  w_reg    <= acc_sat_state;
                    mbq_pkg::DST_Y:  y_reg    <= acc_sat_sample;
                    mbq_pkg::DST_N0: n_reg[0] <= acc_sat_state;
                    mbq_pkg::DST_N1: n_reg[1] <= acc_sat_state;
                    mbq_pkg::DST_N2: n_reg[2] <= acc_sat_state;
                    mbq_pkg::DST_N3: n_reg[3] <= acc_sat_state;
                    default: ;
                endcase
                acc_reg <= {{(mbq_pkg::ACC_W - SW){src_val[SW-1]}}, src_val};
            end
            mbq_pkg::DP_FINISH: begin
                out_chan_reg   <= chan_reg;
                out_sample_reg <= y_reg;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/multichannel_biquad_four_structures_unit.sv @@
// ----------------------------------------------------------------------------
// multichannel_biquad_four_structures_unit
// Multichannel second-order IIR section, direct I/II and transposed I/II.
//
//   channel | dir | bits | contents
//   s_      | in  | 27   | channel, in_sample (Q1.23)
//   m_      | out | 27   | out_channel, out_sample (Q1.23, saturated)
//   cfg_    | in  | 32   | b0, b1, b2, a1, a2 (Q4.28), structure
//
// Each sample runs the microprogram of its structure on the one 24x32
// multiplier, each product term passing through a low half, a high half and
// an accumulate step; a channel outside the range skips the microprogram.
// Synchronous reset clears all delay state through per-channel valid bits.
// A finished sample waits in the output register; the next input is taken
// meanwhile and stalls only at its own writeback if that sample is not taken.
// ----------------------------------------------------------------------------
module multichannel_biquad_four_structures_unit #(
    parameter int CHANNELS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // channel, in_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // out_channel, out_sample
    input  logic                              cfg_wr_en,
    input  logic [mbq_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [mbq_pkg::COEF_W-1:0]        cfg_wr_data
);

    mbq_pkg::dp_cmd_t    cmd;
    mbq_pkg::dp_status_t status;

    mbq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbq_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule
